// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with asynchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/wet_pkg.sv =====
// Shared command and status types for the weight experience table.
package wet_pkg;

    typedef enum logic [3:0] {
        OP_IDLE, OP_PREP, OP_LOAD, OP_ADD, OP_CMPS, OP_CUT, OP_SCAN,
        OP_RDL, OP_RDW, OP_RDR, OP_ML, OP_MR, OP_CMB, OP_DIV, OP_WR, OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic cut_go;
        logic adapt_go;
    } sts_t;

    localparam logic [1:0] REG_LOW_END = 2'd0;
    localparam logic [1:0] REG_SPACING = 2'd1;

endpackage

// ===== rtl/wet_ctrl.sv =====
// Sequencer for the table load and for one request: add, cut, scan, adapt, output.
module wet_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            cfg_hit,
    input  wet_pkg::sts_t   sts,
    output wet_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [15:0] {
        ST_PREP = 16'h0001, ST_LOAD = 16'h0002, ST_IDLE = 16'h0004, ST_ADD  = 16'h0008,
        ST_CMPS = 16'h0010, ST_CUT  = 16'h0020, ST_SCAN = 16'h0040, ST_RDL  = 16'h0080,
        ST_RDW  = 16'h0100, ST_RDR  = 16'h0200, ST_ML   = 16'h0400, ST_MR   = 16'h0800,
        ST_CMB  = 16'h1000, ST_DIV  = 16'h2000, ST_WR   = 16'h4000, ST_OUT  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // result register is loaded during OUT, so done is registered and rises in the cycle after it
    assign done_next = (state_reg == ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PREP;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_PREP: state_next = cfg_hit ? ST_PREP : ST_LOAD;
            ST_LOAD: state_next = cfg_hit ? ST_PREP : (sts.last ? ST_IDLE : ST_LOAD);
            ST_IDLE:
            begin
                if (cfg_hit)
                    state_next = ST_PREP;
                else if (start)
                    state_next = ST_ADD;
            end
            ST_ADD:  state_next = ST_CMPS;
            ST_CMPS: state_next = sts.cut_go ? ST_CUT : ST_SCAN;
            ST_CUT:  state_next = sts.last ? ST_SCAN : ST_CUT;
            ST_SCAN: state_next = sts.last ? ST_RDL : ST_SCAN;
            ST_RDL:  state_next = ST_RDW;
            ST_RDW:  state_next = ST_RDR;
            ST_RDR:  state_next = ST_ML;
            ST_ML:   state_next = sts.adapt_go ? ST_MR : ST_OUT;
            ST_MR:   state_next = ST_CMB;
            ST_CMB:  state_next = ST_DIV;
            ST_DIV:  state_next = sts.last ? ST_WR : ST_DIV;
            ST_WR:   state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_PREP;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_PREP: cmd.op = wet_pkg::OP_PREP;
            ST_LOAD: cmd.op = wet_pkg::OP_LOAD;
            ST_ADD:  cmd.op = wet_pkg::OP_ADD;
            ST_CMPS: cmd.op = wet_pkg::OP_CMPS;
            ST_CUT:  cmd.op = wet_pkg::OP_CUT;
            ST_SCAN: cmd.op = wet_pkg::OP_SCAN;
            ST_RDL:  cmd.op = wet_pkg::OP_RDL;
            ST_RDW:  cmd.op = wet_pkg::OP_RDW;
            ST_RDR:  cmd.op = wet_pkg::OP_RDR;
            ST_ML:   cmd.op = wet_pkg::OP_ML;
            ST_MR:   cmd.op = wet_pkg::OP_MR;
            ST_CMB:  cmd.op = wet_pkg::OP_CMB;
            ST_DIV:  cmd.op = wet_pkg::OP_DIV;
            ST_WR:   cmd.op = wet_pkg::OP_WR;
            ST_OUT:  cmd.op = wet_pkg::OP_OUT;
            default: cmd.op = wet_pkg::OP_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE) || cfg_hit;
    assign done = done_reg;

endmodule

// ===== rtl/wet_dp.sv =====
// Datapath: weight and score tables, scan registers, multiplier and serial divider.
module wet_dp
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  wet_pkg::cmd_t       cmd,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_sel,
    input  logic [31:0]         cfg_data,
    input  logic signed [31:0]  reward,
    output wet_pkg::sts_t       sts,
    output logic signed [31:0]  best_weight
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = (IW > 7) ? IW : 7;
    localparam int AW = 34 + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] CNT_CUT_LAST = CW'(NUM_SLOTS - 2);
    localparam logic [CW-1:0] CNT_DIV_LAST = CW'(64);

    function automatic logic [32:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 33'(-{v[31], v}) : {1'b0, v};
    endfunction

    function automatic logic signed [31:0] sat_wide(input logic signed [AW-1:0] v);
        if (v > AW'(signed'(32'sh7FFFFFFF)))
            sat_wide = 32'sh7FFFFFFF;
        else if (v < AW'(signed'(32'sh80000000)))
            sat_wide = 32'sh80000000;
        else
            sat_wide = v[31:0];
    endfunction

    logic signed [31:0] score_mem [NUM_SLOTS];
    logic signed [31:0] weight_mem [NUM_SLOTS];

    logic signed [31:0] low_reg;
    logic [30:0]        spacing_reg;
    logic signed [AW-1:0] acc_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [31:0] reward_reg;
    logic [IW-1:0]      best_reg, worst_reg, smallest_reg;
    logic [IW-1:0]      cbest_reg, cworst_reg;
    logic signed [31:0] bv_reg, wv_reg;
    logic [32:0]        newmag_reg, smag_reg;
    logic signed [31:0] sl_reg, sw_reg, sr_reg;
    logic [63:0]        ma_reg, mb_reg;
    logic               na_reg, nb_reg, nn_reg;
    logic [64:0]        num_reg;
    logic [33:0]        d_reg;
    logic [33:0]        rem_reg;
    logic [32:0]        q_reg;
    logic signed [31:0] out_reg;

    wet_pkg::op_t op;
    assign op = cmd.op;

    logic [IW-1:0] wm1, wp1, sidx, widx, cut_idx;
    logic signed [31:0] sval, wval;

    assign wm1 = worst_reg - 1'b1;
    assign wp1 = (worst_reg < LAST_IDX) ? worst_reg + 1'b1 : worst_reg;
    assign cut_idx = cnt_reg[IW-1:0] + 1'b1;

    always_comb
    begin
        case (op)
            wet_pkg::OP_ADD:  sidx = best_reg;
            wet_pkg::OP_CMPS: sidx = smallest_reg;
            wet_pkg::OP_CUT:  sidx = cut_idx;
            wet_pkg::OP_RDL:  sidx = wm1;
            wet_pkg::OP_RDR:  sidx = wp1;
            wet_pkg::OP_SCAN: sidx = cnt_reg[IW-1:0];
            default:          sidx = worst_reg;
        endcase
        case (op)
            wet_pkg::OP_ML:   widx = wm1;
            wet_pkg::OP_MR:   widx = wp1;
            wet_pkg::OP_OUT:  widx = best_reg;
            wet_pkg::OP_LOAD: widx = cnt_reg[IW-1:0];
            default:          widx = worst_reg;
        endcase
    end

    assign sval = score_mem[sidx];
    assign wval = weight_mem[widx];

    // Saturating add of the reward to the best score.
    logic signed [32:0] add_sum;
    logic signed [31:0] add_sat;
    assign add_sum = {sval[31], sval} + {reward_reg[31], reward_reg};
    assign add_sat = (add_sum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                     (add_sum < -33'sh080000000) ? 32'sh80000000 : add_sum[31:0];

    // Cut: magnitude reduced by the live smallest magnitude, sign kept.
    logic signed [33:0] cut_d;
    logic [32:0]        cut_ad;
    logic signed [31:0] cut_res;
    assign cut_d  = signed'({1'b0, mag32(sval)}) - signed'({1'b0, smag_reg});
    assign cut_ad = cut_d[33] ? 33'(-cut_d) : cut_d[32:0];
    assign cut_res = sval[31] ? 32'(-signed'({1'b0, cut_ad})) :
                     (cut_ad > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : cut_ad[31:0];

    // Neighbor sums and divisor.
    logic signed [32:0] left_s, right_s;
    logic signed [33:0] den_s;
    assign left_s  = 33'(sl_reg) + 33'(sw_reg);
    assign right_s = 33'(sr_reg) + 33'(sw_reg);
    assign den_s   = 34'(left_s) + 34'(right_s);

    logic signed [32:0] side_s;
    logic [32:0]        side_mag, wmag;
    logic [64:0]        prod;
    logic               prod_neg;
    assign side_s   = (op == wet_pkg::OP_MR) ? right_s : left_s;
    assign side_mag = side_s[32] ? 33'(-side_s) : side_s;
    assign wmag     = mag32(wval);
    assign prod     = 65'(wmag[31:0]) * 65'(side_mag);
    assign prod_neg = (wval[31] != side_s[32]) && (wmag != '0) && (side_mag != '0);

    // Restoring divide step, quotient clamped just above the 32-bit range.
    logic [6:0]  bit_pos;
    logic [34:0] rem_sh;
    logic        ge;
    logic [33:0] q_sh;
    assign bit_pos = 7'(CNT_DIV_LAST) - cnt_reg[6:0];
    assign rem_sh  = {rem_reg, num_reg[bit_pos]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign q_sh    = {q_reg, ge};

    logic [64:0] mag_sum;
    logic        sum_neg;
    always_comb
    begin
        if (na_reg == nb_reg)
        begin
            mag_sum = 65'(ma_reg) + 65'(mb_reg);
            sum_neg = na_reg;
        end
        else if (ma_reg >= mb_reg)
        begin
            mag_sum = 65'(ma_reg - mb_reg);
            sum_neg = na_reg;
        end
        else
        begin
            mag_sum = 65'(mb_reg - ma_reg);
            sum_neg = nb_reg;
        end
        if (mag_sum == '0)
            sum_neg = 1'b0;
    end

    always_comb
    begin
        sts.last = 1'b0;
        case (op)
            wet_pkg::OP_LOAD: sts.last = (cnt_reg == CNT_LAST);
            wet_pkg::OP_SCAN: sts.last = (cnt_reg == CNT_LAST);
            wet_pkg::OP_CUT:  sts.last = (cnt_reg == CNT_CUT_LAST);
            wet_pkg::OP_DIV:  sts.last = (cnt_reg == CNT_DIV_LAST);
            default:          sts.last = 1'b0;
        endcase
    end
    assign sts.cut_go   = newmag_reg < mag32(sval);
    assign sts.adapt_go = (worst_reg != '0) && (worst_reg < LAST_IDX) &&
                          (sw_reg < sl_reg) && (sw_reg < sr_reg) && (den_s != '0);

    always_comb
    begin
        cnt_next = '0;
        if ((op == wet_pkg::OP_LOAD || op == wet_pkg::OP_SCAN ||
             op == wet_pkg::OP_CUT || op == wet_pkg::OP_DIV) && !sts.last)
            cnt_next = cnt_reg + 1'b1;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg      <= -32'sd65536;
            spacing_reg  <= 31'd8192;
            cnt_reg      <= '0;
            best_reg     <= '0;
            worst_reg    <= '0;
            smallest_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                score_mem[i] <= '0;
        end
        else
        begin
            cnt_reg <= (cfg_we) ? '0 : cnt_next;
            if (cfg_we && cfg_sel == wet_pkg::REG_LOW_END)
                low_reg <= cfg_data;
            if (cfg_we && cfg_sel == wet_pkg::REG_SPACING)
                spacing_reg <= cfg_data[30:0];
            case (op)
                wet_pkg::OP_ADD:  score_mem[best_reg] <= add_sat;
                wet_pkg::OP_CMPS:
                begin
                    if (sts.cut_go)
                        smallest_reg <= best_reg;
                end
                wet_pkg::OP_CUT:  score_mem[cut_idx] <= cut_res;
                wet_pkg::OP_SCAN:
                begin
                    if (sts.last)
                    begin
                        if (cnt_reg == '0 || sval > bv_reg)
                            best_reg <= cnt_reg[IW-1:0];
                        else
                            best_reg <= cbest_reg;
                        if (cnt_reg == '0 || sval < wv_reg)
                            worst_reg <= cnt_reg[IW-1:0];
                        else
                            worst_reg <= cworst_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (op)
            wet_pkg::OP_IDLE: reward_reg <= reward;
            wet_pkg::OP_PREP: acc_reg <= AW'(low_reg);
            wet_pkg::OP_LOAD:
            begin
                weight_mem[cnt_reg[IW-1:0]] <= sat_wide(acc_reg);
                acc_reg <= acc_reg + AW'({1'b0, spacing_reg});
            end
            wet_pkg::OP_ADD:  newmag_reg <= mag32(add_sat);
            wet_pkg::OP_CMPS: smag_reg <= sts.cut_go ? newmag_reg : mag32(sval);
            wet_pkg::OP_CUT:
            begin
                if (cut_idx == smallest_reg)
                    smag_reg <= '0;
            end
            wet_pkg::OP_SCAN:
            begin
                if (cnt_reg == '0 || sval > bv_reg)
                begin
                    bv_reg    <= sval;
                    cbest_reg <= cnt_reg[IW-1:0];
                end
                if (cnt_reg == '0 || sval < wv_reg)
                begin
                    wv_reg     <= sval;
                    cworst_reg <= cnt_reg[IW-1:0];
                end
            end
            wet_pkg::OP_RDL:  sl_reg <= sval;
            wet_pkg::OP_RDW:  sw_reg <= sval;
            wet_pkg::OP_RDR:  sr_reg <= sval;
            wet_pkg::OP_ML:
            begin
                ma_reg <= prod[63:0];
                na_reg <= prod_neg;
            end
            wet_pkg::OP_MR:
            begin
                mb_reg <= prod[63:0];
                nb_reg <= prod_neg;
            end
            wet_pkg::OP_CMB:
            begin
                num_reg <= mag_sum;
                nn_reg  <= sum_neg ^ den_s[33];
                d_reg   <= den_s[33] ? 34'(-den_s) : den_s;
                rem_reg <= '0;
                q_reg   <= '0;
            end
            wet_pkg::OP_DIV:
            begin
                rem_reg <= ge ? 34'(rem_sh - {1'b0, d_reg}) : rem_sh[33:0];
                q_reg   <= (q_sh > 34'h0FFFFFFFF) ? 33'h100000000 : q_sh[32:0];
            end
            wet_pkg::OP_WR:
            begin
                if (nn_reg)
                    weight_mem[worst_reg] <= (q_reg >= 33'h080000000) ? 32'sh80000000
                                             : 32'(-signed'({1'b0, q_reg}));
                else
                    weight_mem[worst_reg] <= (q_reg > 33'h07FFFFFFF) ? 32'sh7FFFFFFF
                                             : q_reg[31:0];
            end
            wet_pkg::OP_OUT:  out_reg <= wval;
            default:
            begin
            end
        endcase
    end

    assign best_weight = out_reg;

endmodule

// ===== rtl/weight_experience_table.sv =====
// Top level of the weight experience table.
// Each request (start while busy is low) adds reward to the best slot's score, may
// cut the scores of slots 1 to NUM_SLOTS - 1, rescans for best and worst slot, may
// move the worst interior weight to a score-weighted average of its neighbors, and
// reports the best weight. The single-read score table is swept once per scan and
// per cut, so a cut lengthens a request and skipping the averaging shortens it,
// since the averaging uses a 65-step restoring divider. busy is low again in the
// cycle of done, so the next request can be accepted at the edge that ends it.
// best_weight is valid for the one cycle in which done is high; the receiver
// cannot stall it. A register write while idle or loading reloads the weight
// table, with busy high throughout; the same load runs after reset.
module weight_experience_table
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  reward,
    output logic                done,
    output logic signed [31:0]  best_weight,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    wet_pkg::cmd_t cmd;
    wet_pkg::sts_t sts;
    logic          cfg_hit;

    // only indexes on the register list reload the table
    assign cfg_hit = cfg_we && (cfg_index < 8'd2);

    wet_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cfg_hit (cfg_hit),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    wet_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_hit),
        .cfg_sel     (cfg_index[1:0]),
        .cfg_data    (cfg_data),
        .reward      (reward),
        .sts         (sts),
        .best_weight (best_weight)
    );

endmodule

// ===== rtl/wet_checker.sv =====
// Port-level checks for the weight experience table, bound to the top level.
`include "assert_macros.svh"
module wet_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        cfg_we,
    input logic [7:0]  cfg_index
);

    `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "no busy after request")
    `ASSERT_CLK(a_done_pulse, clk, rst_n, done |=> !done, "done longer than one cycle")
    `ASSERT_CLK(a_done_busy, clk, rst_n, done |-> $past(busy), "done without a request")
    `ASSERT_CLK(a_cfg_busy, clk, rst_n, (cfg_we && cfg_index < 8'd2) |-> busy, "write not busy")

endmodule

bind weight_experience_table wet_checker u_wet_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);
